// File: rtl/lps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, action codes and statistic index map for the lidar point
// statistics unit.
// ----------------------------------------------------------------------------
package lps_pkg;

	localparam int LPS_COUNT_WIDTH = 32;
	localparam int LPS_CLASS_BINS  = 32;
	localparam int LPS_RETURN_BINS = 8;
	localparam int LPS_FLAG_COUNTS = 3;
	localparam int LPS_STAT_WIDTH  = 64;

	// action codes
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ACCUM = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// statistic index map
	localparam logic [6:0] IDX_COUNT      = 7'd0;
	localparam logic [6:0] IDX_COORD_BASE = 7'd1;
	localparam logic [6:0] IDX_COORD_LAST = 7'd6;
	localparam logic [6:0] IDX_INT_BASE   = 7'd7;
	localparam logic [6:0] IDX_INT_LAST   = 7'd8;
	localparam logic [6:0] IDX_TIME_BASE  = 7'd9;
	localparam logic [6:0] IDX_TIME_LAST  = 7'd10;
	localparam logic [6:0] IDX_SMALL_LAST = 7'd24;
	localparam logic [6:0] IDX_RET_BASE   = 7'd25;
	localparam logic [6:0] IDX_RET_LAST   = 7'd32;
	localparam logic [6:0] IDX_PULSE_BASE = 7'd33;
	localparam logic [6:0] IDX_PULSE_LAST = 7'd40;
	localparam logic [6:0] IDX_CLASS_BASE = 7'd41;
	localparam logic [6:0] IDX_CLASS_LAST = 7'd72;
	localparam logic [6:0] IDX_FLAG_BASE  = 7'd73;
	localparam logic [6:0] IDX_FLAG_LAST  = 7'd75;

	// attribute slot of the scan angle among the small attributes
	localparam logic [2:0] ATTR_ANGLE_RANK = 3'd5;

	// update control for one min/max tracker
	typedef struct packed {
		logic clr;
		logic upd;
		logic seed;
	} lps_ctl_t;

endpackage
`default_nettype wire

// File: rtl/lps_minmax.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_minmax
// Running minimum and maximum of one attribute; the first update seeds both.
// ----------------------------------------------------------------------------
module lps_minmax import lps_pkg::*; #(
	parameter int W         = 8,
	parameter bit IS_SIGNED = 1'b0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  lps_ctl_t     ctl,
	input  logic [W-1:0] val,
	output logic [W-1:0] min_q,
	output logic [W-1:0] max_q
);

	// flip the sign bit so one unsigned compare serves both kinds
	localparam logic [W-1:0] BIAS = IS_SIGNED ? (W'(1) << (W - 1)) : '0;

	logic [W-1:0] key;
	logic         below_min;
	logic         above_max;

	assign key       = val ^ BIAS;
	assign below_min = key < (min_q ^ BIAS);
	assign above_max = key > (max_q ^ BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
		end else if (ctl.clr) begin
			min_q <= '0;
			max_q <= '0;
		end else if (ctl.upd) begin
			if (ctl.seed || below_min) begin
				min_q <= val;
			end
			if (ctl.seed || above_max) begin
				max_q <= val;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/lps_sat_cnt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_sat_cnt
// Saturating event counter with synchronous clear.
// ----------------------------------------------------------------------------
module lps_sat_cnt import lps_pkg::*; #(
	parameter int CW = LPS_COUNT_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          inc,
	output logic [CW-1:0] cnt_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr) begin
			cnt_q <= '0;
		end else if (inc && !(&cnt_q)) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

endmodule
`default_nettype wire

// File: rtl/lidar_point_statistics_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_point_statistics_unit
// A read's result passes through the input register and then the result register.
// Throughput: one item per cycle; a read stalls only while the result
// register is full and not being taken. Reset clears all statistics.
// ----------------------------------------------------------------------------
module lidar_point_statistics_unit import lps_pkg::*; #(
	parameter int COUNT_WIDTH = LPS_COUNT_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       action,
	input  logic signed [31:0]               x,
	input  logic signed [31:0]               y,
	input  logic signed [31:0]               z,
	input  logic [15:0]                      intensity,
	input  logic [62:0]                      gps_time,
	input  logic [7:0]                       return_flags,
	input  logic signed [7:0]                angle_rank,
	input  logic [7:0]                       user_byte,
	input  logic [7:0]                       class_byte,
	input  logic [6:0]                       stat_index,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [6:0]                       stat_index_out,
	output logic signed [LPS_STAT_WIDTH-1:0] stat_value,
	output logic                             no_points
);

	localparam int PAD = LPS_STAT_WIDTH - COUNT_WIDTH;

	// ------------------------------------------------------------------
	// Input register: one item per transfer
	// ------------------------------------------------------------------
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [31:0] x_s1, y_s1, z_s1;
	logic [15:0] intensity_s1;
	logic [62:0] gps_time_s1;
	logic [7:0]  return_flags_s1;
	logic [7:0]  angle_rank_s1;
	logic [7:0]  user_byte_s1;
	logic [7:0]  class_byte_s1;
	logic [6:0]  stat_index_s1;

	logic        out_valid_q;
	logic [6:0]  stat_index_out_q;
	logic [63:0] stat_value_q;
	logic        no_points_q;

	logic        read_s1;
	logic        advance;
	logic        go;
	logic        do_clr;
	logic        do_acc;
	logic        any_point_q;

	// A read needs the result register; every other action retires at once.
	assign read_s1  = valid_s1 && (action_s1 == ACT_READ);
	assign advance  = !(read_s1 && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || advance;
	assign go       = valid_s1 && advance;
	assign do_clr   = go && (action_s1 == ACT_CLEAR);
	assign do_acc   = go && (action_s1 == ACT_ACCUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the payload while the stage is stalled
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1       <= action;
			x_s1            <= x;
			y_s1            <= y;
			z_s1            <= z;
			intensity_s1    <= intensity;
			gps_time_s1     <= gps_time;
			return_flags_s1 <= return_flags;
			angle_rank_s1   <= angle_rank;
			user_byte_s1    <= user_byte;
			class_byte_s1   <= class_byte;
			stat_index_s1   <= stat_index;
		end
	end

	// ------------------------------------------------------------------
	// First-point tracking: the first accumulate after clear seeds min/max
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_point_q <= 1'b0;
		end else if (do_clr) begin
			any_point_q <= 1'b0;
		end else if (do_acc) begin
			any_point_q <= 1'b1;
		end
	end

	lps_ctl_t mm_ctl;
	assign mm_ctl = '{clr: do_clr, upd: do_acc, seed: !any_point_q};

	// decoded point fields
	logic [2:0] ret_num;
	logic [2:0] num_ret;
	logic [2:0] ret_bin;
	logic [4:0] cls;

	assign ret_num = return_flags_s1[2:0];
	assign num_ret = return_flags_s1[5:3];
	// return number zero shares bin 0 with return number one
	assign ret_bin = (ret_num == 3'd0) ? 3'd0 : ret_num - 3'd1;
	assign cls     = class_byte_s1[4:0];

	// ------------------------------------------------------------------
	// Min/max trackers
	// ------------------------------------------------------------------
	logic [31:0] coord_min [3];
	logic [31:0] coord_max [3];
	logic [62:0] time_min, time_max;
	logic [15:0] small_min [8];
	logic [15:0] small_max [8];

	logic [15:0] int_min, int_max;
	logic [2:0]  rn_min, rn_max, nr_min, nr_max;
	logic        dir_min, dir_max, edg_min, edg_max;
	logic [7:0]  ang_min, ang_max, usr_min, usr_max, cls_min, cls_max;

	lps_minmax #(.W(32), .IS_SIGNED(1'b1)) u_mm_x (
		.clk, .arst_n, .ctl(mm_ctl), .val(x_s1), .min_q(coord_min[0]), .max_q(coord_max[0])
	);
	lps_minmax #(.W(32), .IS_SIGNED(1'b1)) u_mm_y (
		.clk, .arst_n, .ctl(mm_ctl), .val(y_s1), .min_q(coord_min[1]), .max_q(coord_max[1])
	);
	lps_minmax #(.W(32), .IS_SIGNED(1'b1)) u_mm_z (
		.clk, .arst_n, .ctl(mm_ctl), .val(z_s1), .min_q(coord_min[2]), .max_q(coord_max[2])
	);
	lps_minmax #(.W(63), .IS_SIGNED(1'b0)) u_mm_time (
		.clk, .arst_n, .ctl(mm_ctl), .val(gps_time_s1), .min_q(time_min), .max_q(time_max)
	);
	lps_minmax #(.W(16), .IS_SIGNED(1'b0)) u_mm_int (
		.clk, .arst_n, .ctl(mm_ctl), .val(intensity_s1), .min_q(int_min), .max_q(int_max)
	);
	lps_minmax #(.W(3), .IS_SIGNED(1'b0)) u_mm_rn (
		.clk, .arst_n, .ctl(mm_ctl), .val(ret_num), .min_q(rn_min), .max_q(rn_max)
	);
	lps_minmax #(.W(3), .IS_SIGNED(1'b0)) u_mm_nr (
		.clk, .arst_n, .ctl(mm_ctl), .val(num_ret), .min_q(nr_min), .max_q(nr_max)
	);
	lps_minmax #(.W(1), .IS_SIGNED(1'b0)) u_mm_dir (
		.clk, .arst_n, .ctl(mm_ctl), .val(return_flags_s1[6]), .min_q(dir_min), .max_q(dir_max)
	);
	lps_minmax #(.W(1), .IS_SIGNED(1'b0)) u_mm_edg (
		.clk, .arst_n, .ctl(mm_ctl), .val(return_flags_s1[7]), .min_q(edg_min), .max_q(edg_max)
	);
	lps_minmax #(.W(8), .IS_SIGNED(1'b1)) u_mm_ang (
		.clk, .arst_n, .ctl(mm_ctl), .val(angle_rank_s1), .min_q(ang_min), .max_q(ang_max)
	);
	lps_minmax #(.W(8), .IS_SIGNED(1'b0)) u_mm_usr (
		.clk, .arst_n, .ctl(mm_ctl), .val(user_byte_s1), .min_q(usr_min), .max_q(usr_max)
	);
	lps_minmax #(.W(8), .IS_SIGNED(1'b0)) u_mm_cls (
		.clk, .arst_n, .ctl(mm_ctl), .val(class_byte_s1), .min_q(cls_min), .max_q(cls_max)
	);

	// small attributes, zero-extended, in index-map order
	assign small_min[0] = int_min;
	assign small_max[0] = int_max;
	assign small_min[1] = {13'd0, rn_min};
	assign small_max[1] = {13'd0, rn_max};
	assign small_min[2] = {13'd0, nr_min};
	assign small_max[2] = {13'd0, nr_max};
	assign small_min[3] = {15'd0, dir_min};
	assign small_max[3] = {15'd0, dir_max};
	assign small_min[4] = {15'd0, edg_min};
	assign small_max[4] = {15'd0, edg_max};
	assign small_min[5] = {8'd0, ang_min};
	assign small_max[5] = {8'd0, ang_max};
	assign small_min[6] = {8'd0, usr_min};
	assign small_max[6] = {8'd0, usr_max};
	assign small_min[7] = {8'd0, cls_min};
	assign small_max[7] = {8'd0, cls_max};

	// ------------------------------------------------------------------
	// Saturating counters
	// ------------------------------------------------------------------
	logic [COUNT_WIDTH-1:0] point_count;
	logic [COUNT_WIDTH-1:0] return_bins [LPS_RETURN_BINS];
	logic [COUNT_WIDTH-1:0] pulse_bins  [LPS_RETURN_BINS];
	logic [COUNT_WIDTH-1:0] class_bins  [LPS_CLASS_BINS];
	logic [COUNT_WIDTH-1:0] flag_counts [LPS_FLAG_COUNTS];

	lps_sat_cnt #(.CW(COUNT_WIDTH)) u_cnt_points (
		.clk, .arst_n, .clr(do_clr), .inc(do_acc), .cnt_q(point_count)
	);

	for (genvar b = 0; b < LPS_RETURN_BINS; b++) begin : g_ret
		lps_sat_cnt #(.CW(COUNT_WIDTH)) u_cnt_ret (
			.clk, .arst_n, .clr(do_clr),
			.inc(do_acc && (ret_bin == 3'(b))), .cnt_q(return_bins[b])
		);
		lps_sat_cnt #(.CW(COUNT_WIDTH)) u_cnt_pulse (
			.clk, .arst_n, .clr(do_clr),
			.inc(do_acc && (num_ret == 3'(b))), .cnt_q(pulse_bins[b])
		);
	end

	for (genvar c = 0; c < LPS_CLASS_BINS; c++) begin : g_cls
		lps_sat_cnt #(.CW(COUNT_WIDTH)) u_cnt_cls (
			.clk, .arst_n, .clr(do_clr),
			.inc(do_acc && (cls == 5'(c))), .cnt_q(class_bins[c])
		);
	end

	// synthetic, keypoint, withheld: class byte bits above the class code
	for (genvar f = 0; f < LPS_FLAG_COUNTS; f++) begin : g_flag
		lps_sat_cnt #(.CW(COUNT_WIDTH)) u_cnt_flag (
			.clk, .arst_n, .clr(do_clr),
			.inc(do_acc && class_byte_s1[5 + f]), .cnt_q(flag_counts[f])
		);
	end

	// ------------------------------------------------------------------
	// Read select: pick one statistic by index
	// ------------------------------------------------------------------
	logic [6:0]  idx_coord, idx_small, idx_ret, idx_pulse, idx_class, idx_flag;
	logic [2:0]  attr_k;
	logic [15:0] small_v;
	logic        pick_min;
	logic [63:0] read_value;

	assign idx_coord = stat_index_s1 - IDX_COORD_BASE;
	assign idx_small = stat_index_s1 - IDX_TIME_BASE;
	assign idx_ret   = stat_index_s1 - IDX_RET_BASE;
	assign idx_pulse = stat_index_s1 - IDX_PULSE_BASE;
	assign idx_class = stat_index_s1 - IDX_CLASS_BASE;
	assign idx_flag  = stat_index_s1 - IDX_FLAG_BASE;

	// minimum sits at the odd index of every min/max pair
	assign pick_min = stat_index_s1[0];
	// intensity is attribute 0; the rest follow the time pair
	assign attr_k   = (stat_index_s1 <= IDX_INT_LAST) ? 3'd0 : idx_small[3:1];
	assign small_v  = pick_min ? small_min[attr_k] : small_max[attr_k];

	always_comb begin
		read_value = '0;
		if (stat_index_s1 == IDX_COUNT) begin
			read_value = {{PAD{1'b0}}, point_count};
		end else if (stat_index_s1 <= IDX_COORD_LAST) begin
			read_value = pick_min
				? {{32{coord_min[idx_coord[2:1]][31]}}, coord_min[idx_coord[2:1]]}
				: {{32{coord_max[idx_coord[2:1]][31]}}, coord_max[idx_coord[2:1]]};
		end else if (stat_index_s1 <= IDX_INT_LAST) begin
			read_value = {48'd0, small_v};
		end else if (stat_index_s1 <= IDX_TIME_LAST) begin
			read_value = pick_min ? {1'b0, time_min} : {1'b0, time_max};
		end else if (stat_index_s1 <= IDX_SMALL_LAST) begin
			// scan angle reads back sign-extended
			if (attr_k == ATTR_ANGLE_RANK) begin
				read_value = {{56{small_v[7]}}, small_v[7:0]};
			end else begin
				read_value = {48'd0, small_v};
			end
		end else if (stat_index_s1 <= IDX_RET_LAST) begin
			read_value = {{PAD{1'b0}}, return_bins[idx_ret[2:0]]};
		end else if (stat_index_s1 <= IDX_PULSE_LAST) begin
			read_value = {{PAD{1'b0}}, pulse_bins[idx_pulse[2:0]]};
		end else if (stat_index_s1 <= IDX_CLASS_LAST) begin
			read_value = {{PAD{1'b0}}, class_bins[idx_class[4:0]]};
		end else if (stat_index_s1 <= IDX_FLAG_LAST) begin
			read_value = {{PAD{1'b0}}, flag_counts[idx_flag[1:0]]};
		end
	end

	// ------------------------------------------------------------------
	// Result register: holds a read until the consumer takes it
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (read_s1 && advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read_s1 && advance) begin
			stat_index_out_q <= stat_index_s1;
			stat_value_q     <= read_value;
			no_points_q      <= !any_point_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign stat_index_out = stat_index_out_q;
	assign stat_value     = stat_value_q;
	assign no_points      = no_points_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_tracks_seen: assert property (@(posedge clk) disable iff (!arst_n)
		any_point_q == (point_count != '0))
		else $error("point count and first-point flag disagree");

	a_accum_sets_seen: assert property (@(posedge clk) disable iff (!arst_n)
		do_acc |=> any_point_q)
		else $error("accumulate did not mark a point as seen");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (out_valid_q && !out_ready))
		else $error("input stage stalled with room in result register");

	a_x_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		any_point_q |-> ($signed(coord_min[0]) <= $signed(coord_max[0])))
		else $error("x minimum above x maximum");

endmodule
`default_nettype wire
